FILE: rtl/binary_min_heap_queue_defines.svh
// assertion macros shared by the heap queue rtl
// no dependencies; included by the controller and the datapath
`ifndef BINARY_MIN_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_DEFINES_SVH

// same-cycle implication
`define BMHQ_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("heap queue assertion failed");

// next-cycle implication
`define BMHQ_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("heap queue assertion failed");

`endif

FILE: rtl/bmhq_pkg.sv
// shared types and codes for the binary min-heap queue
// used by bmhq_ctrl, bmhq_datapath and binary_min_heap_queue
`default_nettype none

package bmhq_pkg;

  typedef logic signed [63:0] key_t;

  localparam logic [1:0] KIND_PUSH = 2'd0;
  localparam logic [1:0] KIND_POP  = 2'd1;
  localparam logic [1:0] KIND_PEEK = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;

  localparam logic [3:0] OP_NONE       = 4'd0;
  localparam logic [3:0] OP_LOAD       = 4'd1;
  localparam logic [3:0] OP_SET_OVER   = 4'd2;
  localparam logic [3:0] OP_SET_UNDER  = 4'd3;
  localparam logic [3:0] OP_PUSH_START = 4'd4;
  localparam logic [3:0] OP_RD_ROOT    = 4'd5;
  localparam logic [3:0] OP_POP_START  = 4'd6;
  localparam logic [3:0] OP_UP_READ    = 4'd7;
  localparam logic [3:0] OP_UP_STEP    = 4'd8;
  localparam logic [3:0] OP_PEEK_CAP   = 4'd9;
  localparam logic [3:0] OP_POP_CAP    = 4'd10;
  localparam logic [3:0] OP_HOLD_CAP   = 4'd11;
  localparam logic [3:0] OP_DN_READ_L  = 4'd12;
  localparam logic [3:0] OP_DN_LEFT    = 4'd13;
  localparam logic [3:0] OP_DN_RIGHT   = 4'd14;
  localparam logic [3:0] OP_DN_MOVE    = 4'd15;

  typedef struct packed {
    logic [3:0] op;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       empty;
    logic       full;
    logic       at_root;
    logic       up_less;
    logic       left_in;
    logic       right_in;
    logic       best_is_pos;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/bmhq_ctrl.sv
// sequencing state machine for the heap queue
// depends on bmhq_pkg and binary_min_heap_queue_defines.svh
`default_nettype none
`include "binary_min_heap_queue_defines.svh"

module bmhq_ctrl
  import bmhq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  wire logic     m_tready,
  input  wire dp_stat_t st,
  output dp_cmd_t       cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_UP_READ  = 4'd2;
  localparam logic [3:0] S_UP_STEP  = 4'd3;
  localparam logic [3:0] S_PEEK     = 4'd4;
  localparam logic [3:0] S_POP_CAP  = 4'd5;
  localparam logic [3:0] S_HOLD     = 4'd6;
  localparam logic [3:0] S_DN_READ  = 4'd7;
  localparam logic [3:0] S_DN_LEFT  = 4'd8;
  localparam logic [3:0] S_DN_RIGHT = 4'd9;
  localparam logic [3:0] S_DN_MOVE  = 4'd10;
  localparam logic [3:0] S_FINISH   = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_free;
  logic       leaf_done;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // no left child means the hole is a leaf: finish after the final write
  assign leaf_done = (state == S_DN_READ) && !st.left_in;

  always_comb begin
    state_next   = state;
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.kind)
          KIND_PUSH: begin
            if (st.full) begin
              cmd.op     = OP_SET_OVER;
              state_next = S_FINISH;
            end else begin
              cmd.op     = OP_PUSH_START;
              state_next = S_UP_READ;
            end
          end
          KIND_POP: begin
            if (st.empty) begin
              cmd.op     = OP_SET_UNDER;
              state_next = S_FINISH;
            end else begin
              cmd.op     = OP_POP_START;
              state_next = S_POP_CAP;
            end
          end
          KIND_PEEK: begin
            if (st.empty) begin
              cmd.op     = OP_SET_UNDER;
              state_next = S_FINISH;
            end else begin
              cmd.op     = OP_RD_ROOT;
              state_next = S_PEEK;
            end
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_UP_READ: begin
        cmd.op     = OP_UP_READ;
        state_next = st.at_root ? S_FINISH : S_UP_STEP;
      end
      S_UP_STEP: begin
        cmd.op     = OP_UP_STEP;
        state_next = st.up_less ? S_UP_READ : S_FINISH;
      end
      S_PEEK: begin
        cmd.op     = OP_PEEK_CAP;
        state_next = S_FINISH;
      end
      S_POP_CAP: begin
        cmd.op     = OP_POP_CAP;
        state_next = st.empty ? S_FINISH : S_HOLD;
      end
      S_HOLD: begin
        cmd.op     = OP_HOLD_CAP;
        state_next = S_DN_READ;
      end
      S_DN_READ: begin
        cmd.op     = OP_DN_READ_L;
        state_next = leaf_done ? S_FINISH : S_DN_LEFT;
      end
      S_DN_LEFT: begin
        cmd.op     = OP_DN_LEFT;
        state_next = st.right_in ? S_DN_RIGHT : S_DN_MOVE;
      end
      S_DN_RIGHT: begin
        cmd.op     = OP_DN_RIGHT;
        state_next = S_DN_MOVE;
      end
      S_DN_MOVE: begin
        cmd.op     = OP_DN_MOVE;
        state_next = st.best_is_pos ? S_FINISH : S_DN_READ;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `BMHQ_ASSERT_IMP(a_load_when_free, clk, rst, cmd.out_load, !m_tvalid || m_tready)
  `BMHQ_ASSERT_IMP(a_up_not_root, clk, rst, state == S_UP_STEP, !st.at_root && !leaf_done)
  `BMHQ_ASSERT_IMP(a_right_after_left, clk, rst, state == S_DN_RIGHT, $past(state) == S_DN_LEFT && $past(st.right_in))

endmodule

`default_nettype wire

FILE: rtl/bmhq_datapath.sv
// heap storage, count, position registers and key compares
// depends on bmhq_pkg and binary_min_heap_queue_defines.svh
`default_nettype none
`include "binary_min_heap_queue_defines.svh"

module bmhq_datapath
  import bmhq_pkg::*;
#(
  parameter int CAPACITY = 1024,
  localparam int IDX_W = $clog2(CAPACITY),
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [1:0] in_kind,
  input  wire key_t       in_key,
  input  wire dp_cmd_t    cmd,
  output dp_stat_t        st,
  output key_t            out_value,
  output logic [1:0]      out_status,
  output logic [CNT_W-1:0] out_count
);

  localparam int CHW = IDX_W + 2;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  key_t heap_mem [CAPACITY];

  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] best;
  logic [1:0]       kind_q;
  logic [1:0]       status_q;
  key_t             hold;
  key_t             bv;
  key_t             val_q;
  key_t             rdata;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  key_t             wr_data;

  logic [IDX_W-1:0] up_idx;
  logic [CHW-1:0]   lc_w;
  logic [CHW-1:0]   rc_w;
  logic [CHW-1:0]   n_w;
  logic             left_in;
  logic             right_in;
  logic             up_less;

  assign up_idx   = IDX_W'((pos - IDX_W'(1)) >> 1);
  assign lc_w     = CHW'({pos, 1'b1});
  assign rc_w     = lc_w + CHW'(1);
  assign n_w      = CHW'(cnt);
  assign left_in  = lc_w < n_w;
  assign right_in = rc_w < n_w;
  assign up_less  = hold < rdata;

  assign st.kind        = kind_q;
  assign st.empty       = (cnt == '0);
  assign st.full        = (cnt == CAP_CNT);
  assign st.at_root     = (pos == '0);
  assign st.up_less     = up_less;
  assign st.left_in     = left_in;
  assign st.right_in    = right_in;
  assign st.best_is_pos = (best == pos);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = hold;
    case (cmd.op)
      OP_RD_ROOT, OP_POP_START: rd_en = 1'b1;
      OP_UP_READ: begin
        if (pos == '0) begin
          wr_en = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = up_idx;
        end
      end
      OP_UP_STEP: begin
        wr_en = 1'b1;
        if (up_less) begin
          wr_data = rdata;
        end
      end
      OP_POP_CAP: begin
        rd_en   = 1'b1;
        rd_addr = cnt[IDX_W-1:0];
      end
      OP_DN_READ_L: begin
        if (left_in) begin
          rd_en   = 1'b1;
          rd_addr = lc_w[IDX_W-1:0];
        end else begin
          wr_en = 1'b1;
        end
      end
      OP_DN_LEFT: begin
        if (right_in) begin
          rd_en   = 1'b1;
          rd_addr = rc_w[IDX_W-1:0];
        end
      end
      OP_DN_MOVE: begin
        wr_en = 1'b1;
        if (best != pos) begin
          wr_data = bv;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= heap_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      case (cmd.op)
        OP_PUSH_START: cnt <= cnt + CNT_W'(1);
        OP_POP_START:  cnt <= cnt - CNT_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        kind_q   <= in_kind;
        hold     <= in_key;
        val_q    <= '0;
        status_q <= ST_OK;
      end
      OP_SET_OVER:   status_q <= ST_OVER;
      OP_SET_UNDER:  status_q <= ST_UNDER;
      OP_PUSH_START: pos <= cnt[IDX_W-1:0];
      OP_UP_STEP: begin
        if (up_less) begin
          pos <= up_idx;
        end
      end
      OP_PEEK_CAP, OP_POP_CAP: val_q <= rdata;
      OP_HOLD_CAP: begin
        hold <= rdata;
        pos  <= '0;
      end
      OP_DN_LEFT: begin
        if (rdata < hold) begin
          best <= lc_w[IDX_W-1:0];
          bv   <= rdata;
        end else begin
          best <= pos;
          bv   <= hold;
        end
      end
      OP_DN_RIGHT: begin
        if (rdata < bv) begin
          best <= rc_w[IDX_W-1:0];
          bv   <= rdata;
        end
      end
      OP_DN_MOVE: pos <= best;
      default: ;
    endcase
    if (cmd.out_load) begin
      out_value  <= val_q;
      out_status <= status_q;
      out_count  <= cnt;
    end
  end

  `BMHQ_ASSERT_IMP(a_cnt_bound, clk, rst, 1'b1, cnt <= CAP_CNT)
  `BMHQ_ASSERT_NXT(a_over_keeps_cnt, clk, rst, cmd.op == OP_SET_OVER, $stable(cnt))
  `BMHQ_ASSERT_NXT(a_pop_dec_cnt, clk, rst, cmd.op == OP_POP_START, cnt == CNT_W'($past(cnt) - CNT_W'(1)))

endmodule

`default_nettype wire

FILE: rtl/binary_min_heap_queue.sv
// top level of the binary min-heap priority queue
// depends on bmhq_pkg, bmhq_ctrl and bmhq_datapath
//
// channel   dir  tdata                         tuser
// s_*       in   key[63:0]                     kind[1:0]
// m_*       out  value[63:0], count, zero pad  status[1:0]
//
// push: the key climbs from the new tail slot while it is less than its parent
// pop: the last entry fills the root hole and sinks while a child is less than it
// peek reads the root; underflow, overflow and unused kinds finish without heap access
// the heap memory has a single read port, so the walks read one entry at a time
// one transaction is worked at a time; a stalled result holds the controller and s_tready low
// rst clears the count and the control; heap entries need no clearing
`default_nettype none

module binary_min_heap_queue
  import bmhq_pkg::*;
#(
  parameter int CAPACITY = 1024,
  localparam int CNT_W = $clog2(CAPACITY + 1),
  localparam int OUT_W = ((64 + CNT_W + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [63:0]      s_tdata,   // key
  input  wire logic [1:0]       s_tuser,   // kind
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [OUT_W-1:0]      m_tdata,   // value, count, zero pad
  output logic [1:0]            m_tuser    // status
);

  dp_cmd_t          cmd;
  dp_stat_t         st;
  key_t             out_value;
  logic [CNT_W-1:0] out_count;

  bmhq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .st       (st),
    .cmd      (cmd)
  );

  bmhq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .in_kind    (s_tuser),
    .in_key     (s_tdata),
    .cmd        (cmd),
    .st         (st),
    .out_value  (out_value),
    .out_status (m_tuser),
    .out_count  (out_count)
  );

  assign m_tdata = OUT_W'({out_count, out_value});

endmodule

`default_nettype wire
